### src/srs_pkg.sv
// Shared types, constants and codes of the sensor reading smoother.
package srs_pkg;

   localparam int BYTE_W     = 8;
   localparam int VALUE_W    = 16;
   localparam int SCALED_W   = 21;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int DIGIT_W    = 4;
   localparam int COUNT_W    = 8;

   localparam int DEFAULT_WINDOW = 8;

   localparam logic [BYTE_W-1:0]   CRC_POLY  = 8'h31;
   localparam logic [BYTE_W-1:0]   CRC_INIT  = 8'hFF;
   localparam int                  CRC_STEPS = 16;
   localparam logic [SCALED_W-1:0] SCALE     = 21'd20;

   localparam logic [DIGIT_W-1:0] ERR_TICKS     = 4'd8;
   localparam logic [DIGIT_W-1:0] ERR_DIGIT_MIN = 4'd6;
   localparam logic [DIGIT_W-1:0] ERR_DIGIT_MAX = 4'd9;

   localparam logic [COUNT_W-1:0] LINK_TIMEOUT_RST   = 8'd5;
   localparam logic [VALUE_W-1:0] VALUE_MAX_RST      = 16'd9999;
   localparam logic [VALUE_W-1:0] FAST_THRESHOLD_RST = 16'd200;
   localparam logic [COUNT_W-1:0] FAST_DELAY_RST     = 8'd1;
   localparam logic [COUNT_W-1:0] SLOW_DELAY_RST     = 8'd5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINK_TIMEOUT   = 3'd0,
      CSR_VALUE_MAX      = 3'd1,
      CSR_FAST_THRESHOLD = 3'd2,
      CSR_FAST_DELAY     = 3'd3,
      CSR_SLOW_DELAY     = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CRC,
      ST_APPLY,
      ST_ERROR,
      ST_READ,
      ST_WRITE,
      ST_DIVIDE,
      ST_FOLLOW
   } state_type;

endpackage

### src/srs_if.sv
// Handshake channel interfaces: sensor frames, display results and register writes.
interface srs_req_if;
   import srs_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] high_byte;
   logic [BYTE_W-1:0] low_byte;
   logic [BYTE_W-1:0] check_byte;
   modport source (output valid, output high_byte, output low_byte, output check_byte,
                   input ready);
   modport sink   (input valid, input high_byte, input low_byte, input check_byte,
                   output ready);
endinterface

interface srs_rsp_if;
   import srs_pkg::*;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] display_value;
   logic               link_lost;
   logic               frame_good;
   modport source (output valid, output display_value, output link_lost,
                   output frame_good, input ready);
   modport sink   (input valid, input display_value, input link_lost,
                   input frame_good, output ready);
endinterface

interface srs_csr_if;
   import srs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### src/srs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module srs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/sensor_reading_smoother.sv
// Top level of the sensor reading smoother: frame check, moving average and display follower.
//
// Usage: one request transaction on req_ch per sensor poll carries the three frame
// bytes (index high, index low, CRC-8). Every request yields exactly one response
// transaction on rsp_ch with the display value, the link-lost flag and whether this
// frame passed its check. Register writes on csr_ch are always taken (ready is tied
// high) and should be issued only while no request is in flight.
// Sequence: the CRC is checked one bit per cycle, then the APPLY state applies the
// frame. While the link is lost the ERROR state loads the response register once it is free.
// Otherwise the READ and WRITE states read and write the window memory, and the
// average comes from a restoring divider that retires one quotient bit per cycle
// over the 16 + clog2(WINDOW) bit sum; the FOLLOW state then runs the follower.
// A new request is taken only once the previous one has reached the response
// register and the sequencer is back in idle.
// Reset clears the link countdown to its default reload, the average and the display;
// the first frame after reset is not checked. The window memory needs no clearing.
// A stalled receiver holds the response register; the next request is still taken
// and runs until it needs that register, then waits there.
module sensor_reading_smoother #(
   parameter int WINDOW = srs_pkg::DEFAULT_WINDOW
) (
   input  logic      clock,
   input  logic      reset,
   srs_req_if.sink   req_ch,
   srs_rsp_if.source rsp_ch,
   srs_csr_if.sink   csr_ch
);

   import srs_pkg::*;

   localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SUM_W  = VALUE_W + IDX_W;
   localparam int STEP_W = $clog2(SUM_W);

   // Configuration registers.
   logic [COUNT_W-1:0] link_timeout_ff, link_timeout_in;
   logic [VALUE_W-1:0] value_max_ff, value_max_in;
   logic [VALUE_W-1:0] fast_threshold_ff, fast_threshold_in;
   logic [COUNT_W-1:0] fast_delay_ff, fast_delay_in;
   logic [COUNT_W-1:0] slow_delay_ff, slow_delay_in;

   // Filter state.
   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] countdown_ff, countdown_in;
   logic               command_sent_ff, command_sent_in;
   logic [VALUE_W-1:0] latest_ff, latest_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic               full_ff, full_in;
   logic [COUNT_W-1:0] follow_count_ff, follow_count_in;
   logic [VALUE_W-1:0] shown_ff, shown_in;
   logic [DIGIT_W-1:0] err_digit_ff, err_digit_in;
   logic [DIGIT_W-1:0] err_ticks_ff, err_ticks_in;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_display_ff, rsp_display_in;
   logic               rsp_lost_ff, rsp_lost_in;
   logic               rsp_good_ff, rsp_good_in;

   // Working registers of the sequencer and the shared step unit.
   logic [BYTE_W-1:0]    high_ff, high_in;
   logic [BYTE_W-1:0]    low_ff, low_in;
   logic [BYTE_W-1:0]    check_ff, check_in;
   logic [BYTE_W-1:0]    crc_ff, crc_in;
   logic [2*BYTE_W-1:0]  shift_ff, shift_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 good_ff, good_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     divisor_ff, divisor_in;

   // Window memory.
   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [VALUE_W-1:0] ram_rd_data;

   // Combinational helpers.
   logic               out_free;
   logic               crc_fb;
   logic [SCALED_W-1:0] scaled;
   logic [COUNT_W-1:0] cd_next;
   logic [CNT_W:0]     trial;
   logic [CNT_W-1:0]   count_next;
   logic [SUM_W-1:0]   sum_next;
   logic [VALUE_W-1:0] target;
   logic [VALUE_W-1:0] diff;
   logic [COUNT_W-1:0] delay;
   logic [COUNT_W-1:0] fcount;
   logic [DIGIT_W-1:0] ticks_next;
   logic [DIGIT_W-1:0] digit_next;

   srs_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (WINDOW)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pos_ff),
      .wr_data (latest_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (pos_ff),
      .rd_data (ram_rd_data)
   );

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign csr_ch.ready         = 1'b1;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.display_value = rsp_display_ff;
   assign rsp_ch.link_lost     = rsp_lost_ff;
   assign rsp_ch.frame_good    = rsp_good_ff;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign crc_fb   = crc_ff[BYTE_W-1] ^ shift_ff[2*BYTE_W-1];
   assign scaled   = SCALED_W'({high_ff, low_ff}) * SCALE;
   assign trial    = {rem_ff, quo_ff[SUM_W-1]};

   always_comb begin
      link_timeout_in   = link_timeout_ff;
      value_max_in      = value_max_ff;
      fast_threshold_in = fast_threshold_ff;
      fast_delay_in     = fast_delay_ff;
      slow_delay_in     = slow_delay_ff;
      state_in          = state_ff;
      countdown_in      = countdown_ff;
      command_sent_in   = command_sent_ff;
      latest_in         = latest_ff;
      sum_in            = sum_ff;
      pos_in            = pos_ff;
      full_in           = full_ff;
      follow_count_in   = follow_count_ff;
      shown_in          = shown_ff;
      err_digit_in      = err_digit_ff;
      err_ticks_in      = err_ticks_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ch.ready;
      rsp_display_in    = rsp_display_ff;
      rsp_lost_in       = rsp_lost_ff;
      rsp_good_in       = rsp_good_ff;
      high_in           = high_ff;
      low_in            = low_ff;
      check_in          = check_ff;
      crc_in            = crc_ff;
      shift_in          = shift_ff;
      step_in           = step_ff;
      good_in           = good_ff;
      quo_in            = quo_ff;
      rem_in            = rem_ff;
      divisor_in        = divisor_ff;
      ram_wr_en         = 1'b0;
      ram_rd_en         = 1'b0;
      cd_next           = '0;
      count_next        = CNT_W'(pos_ff) + CNT_W'(1);
      sum_next          = sum_ff;
      target            = quo_ff[VALUE_W-1:0];
      diff              = '0;
      delay             = slow_delay_ff;
      fcount            = follow_count_ff + COUNT_W'(1);
      ticks_next        = err_ticks_ff + DIGIT_W'(1);
      digit_next        = err_digit_ff;

      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_LINK_TIMEOUT:   link_timeout_in   = csr_ch.data[COUNT_W-1:0];
            CSR_VALUE_MAX:      value_max_in      = csr_ch.data;
            CSR_FAST_THRESHOLD: fast_threshold_in = csr_ch.data;
            CSR_FAST_DELAY:     fast_delay_in     = csr_ch.data[COUNT_W-1:0];
            CSR_SLOW_DELAY:     slow_delay_in     = csr_ch.data[COUNT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               high_in  = req_ch.high_byte;
               low_in   = req_ch.low_byte;
               check_in = req_ch.check_byte;
               crc_in   = CRC_INIT;
               shift_in = {req_ch.high_byte, req_ch.low_byte};
               step_in  = '0;
               state_in = ST_CRC;
            end
         end
         ST_CRC: begin
            // One message bit per cycle, most significant bit first.
            crc_in   = {crc_ff[BYTE_W-2:0], 1'b0} ^ (crc_fb ? CRC_POLY : '0);
            shift_in = {shift_ff[2*BYTE_W-2:0], 1'b0};
            step_in  = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(CRC_STEPS - 1)) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cd_next = (countdown_ff != '0) ? countdown_ff - COUNT_W'(1) : countdown_ff;
            good_in = 1'b0;
            if (!command_sent_ff) begin
               command_sent_in = 1'b1;
            end else if (crc_ff == check_ff) begin
               good_in   = 1'b1;
               cd_next   = link_timeout_ff;
               latest_in = (scaled > SCALED_W'(value_max_ff)) ? value_max_ff
                                                            : scaled[VALUE_W-1:0];
            end
            countdown_in = cd_next;
            state_in     = (cd_next == '0) ? ST_ERROR : ST_READ;
         end
         ST_ERROR: begin
            if (out_free) begin
               digit_next = err_digit_ff;
               if (ticks_next >= ERR_TICKS) begin
                  ticks_next = '0;
                  digit_next = err_digit_ff + DIGIT_W'(1);
                  if (digit_next > ERR_DIGIT_MAX) begin
                     digit_next = ERR_DIGIT_MIN;
                  end
               end
               err_ticks_in    = ticks_next;
               err_digit_in    = digit_next;
               shown_in        = VALUE_W'(digit_next);
               follow_count_in = '0;
               rsp_valid_in    = 1'b1;
               rsp_display_in  = VALUE_W'(digit_next);
               rsp_lost_in     = 1'b1;
               rsp_good_in     = good_ff;
               state_in        = ST_IDLE;
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_WRITE;
         end
         ST_WRITE: begin
            ram_wr_en = 1'b1;
            if (full_ff) begin
               sum_next   = sum_ff - SUM_W'(ram_rd_data) + SUM_W'(latest_ff);
               divisor_in = CNT_W'(WINDOW);
            end else begin
               sum_next   = sum_ff + SUM_W'(latest_ff);
               divisor_in = count_next;
            end
            if (count_next == CNT_W'(WINDOW)) begin
               pos_in  = '0;
               full_in = 1'b1;
            end else begin
               pos_in = count_next[IDX_W-1:0];
            end
            sum_in   = sum_next;
            quo_in   = sum_next;
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            // Restoring division, one quotient bit per cycle.
            if (trial >= {1'b0, divisor_ff}) begin
               rem_in = CNT_W'(trial - {1'b0, divisor_ff});
               quo_in = {quo_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = trial[CNT_W-1:0];
               quo_in = {quo_ff[SUM_W-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = ST_FOLLOW;
            end
         end
         ST_FOLLOW: begin
            if (out_free) begin
               diff  = (shown_ff >= target) ? shown_ff - target : target - shown_ff;
               delay = (diff >= fast_threshold_ff) ? fast_delay_ff : slow_delay_ff;
               if (fcount >= delay) begin
                  follow_count_in = '0;
                  shown_in        = target;
                  rsp_display_in  = target;
               end else begin
                  follow_count_in = fcount;
                  rsp_display_in  = shown_ff;
               end
               rsp_valid_in = 1'b1;
               rsp_lost_in  = 1'b0;
               rsp_good_in  = good_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_timeout_ff   <= LINK_TIMEOUT_RST;
         value_max_ff      <= VALUE_MAX_RST;
         fast_threshold_ff <= FAST_THRESHOLD_RST;
         fast_delay_ff     <= FAST_DELAY_RST;
         slow_delay_ff     <= SLOW_DELAY_RST;
         state_ff          <= ST_IDLE;
         countdown_ff      <= LINK_TIMEOUT_RST;
         command_sent_ff   <= 1'b0;
         latest_ff         <= '0;
         sum_ff            <= '0;
         pos_ff            <= '0;
         full_ff           <= 1'b0;
         follow_count_ff   <= '0;
         shown_ff          <= '0;
         err_digit_ff      <= ERR_DIGIT_MIN;
         err_ticks_ff      <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         link_timeout_ff   <= link_timeout_in;
         value_max_ff      <= value_max_in;
         fast_threshold_ff <= fast_threshold_in;
         fast_delay_ff     <= fast_delay_in;
         slow_delay_ff     <= slow_delay_in;
         state_ff          <= state_in;
         countdown_ff      <= countdown_in;
         command_sent_ff   <= command_sent_in;
         latest_ff         <= latest_in;
         sum_ff            <= sum_in;
         pos_ff            <= pos_in;
         full_ff           <= full_in;
         follow_count_ff   <= follow_count_in;
         shown_ff          <= shown_in;
         err_digit_ff      <= err_digit_in;
         err_ticks_ff      <= err_ticks_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_display_ff <= rsp_display_in;
      rsp_lost_ff    <= rsp_lost_in;
      rsp_good_ff    <= rsp_good_in;
      high_ff        <= high_in;
      low_ff         <= low_in;
      check_ff       <= check_in;
      crc_ff         <= crc_in;
      shift_ff       <= shift_in;
      step_ff        <= step_in;
      good_ff        <= good_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      divisor_ff     <= divisor_in;
   end

endmodule
